// File: rtl/stall_occupancy_detector_top_assert.svh
// Assertion macros for the stall occupancy detector.
// Included by the top level only; needs no package.
`ifndef STALL_OCCUPANCY_DETECTOR_TOP_ASSERT_SVH
`define STALL_OCCUPANCY_DETECTOR_TOP_ASSERT_SVH

// Implication in the same cycle, checked outside reset.
`define SOD_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sod assertion failed");

// Implication in the next cycle, checked outside reset.
`define SOD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sod assertion failed");

`endif

// File: rtl/sod_pkg.sv
// Shared constants and types of the stall occupancy detector.
// Used by every module of the block; depends on nothing.
package sod_pkg;

    localparam int unsigned NUM_STALLS   = 4;
    localparam int unsigned AVG_ROUNDS   = 4;
    localparam int unsigned STALL_SLOTS  = 4;
    localparam int unsigned CH_W         = 2;
    localparam int unsigned RAW_W        = 16;
    localparam int unsigned SAT_W        = 10;
    localparam int unsigned AVG_W        = 8;
    localparam int unsigned THR_W        = 8;
    localparam int unsigned CFG_IDX_W    = 4;
    localparam int unsigned RAW_MAX      = 1023;
    localparam int unsigned SCALED_MAX   = 255;
    localparam int unsigned THRESH_RESET = 5;

    localparam int unsigned RND_W     = (AVG_ROUNDS > 1) ? $clog2(AVG_ROUNDS) : 1;
    localparam int unsigned SUM_W     = $clog2(SCALED_MAX * AVG_ROUNDS + 1);
    localparam int unsigned AVG_SHIFT = SUM_W + $clog2(AVG_ROUNDS) + 1;
    localparam int unsigned RECIP_W   = AVG_SHIFT + 1;
    localparam longint unsigned AVG_RECIP =
        ((64'd1 << AVG_SHIFT) + AVG_ROUNDS - 1) / AVG_ROUNDS;

    localparam int unsigned FIFO_DEPTH = 2;
    localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [AVG_W-1:0] scaled;
        logic [CH_W-1:0]  ch;
        logic             done;
    } t_work;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

endpackage

// File: rtl/sod_front.sv
// Front end: accepts raw counts, scales them and tags stall and window end.
// Depends on sod_pkg.
module sod_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [sod_pkg::RAW_W-1:0]    i_raw,
    input  sod_pkg::t_fifo_stat          i_stat,
    output logic                         o_push,
    output sod_pkg::t_work               o_word
);

    logic [sod_pkg::CH_W-1:0]   r_ch, n_ch;
    logic [sod_pkg::RND_W-1:0]  r_rnd, n_rnd;
    logic [sod_pkg::SAT_W-1:0]  w_sat;
    logic [17:0]                w_prod;
    logic [7:0]                 w_quo;
    logic [10:0]                w_rem;
    logic [7:0]                 w_scaled;
    logic                       w_last_ch;
    logic                       w_last_rnd;

    assign o_ready = !i_stat.full;
    assign o_push  = i_valid && !i_stat.full;

    // y / 1023 as (y >> 10) with one correction, since y = q*1023 + (q + low bits).
    always_comb begin
        w_sat    = (i_raw > sod_pkg::RAW_W'(sod_pkg::RAW_MAX)) ?
                   sod_pkg::SAT_W'(sod_pkg::RAW_MAX) : i_raw[sod_pkg::SAT_W-1:0];
        w_prod   = 18'(w_sat) * 18'(sod_pkg::SCALED_MAX);
        w_quo    = w_prod[17:10];
        w_rem    = {1'b0, w_prod[9:0]} + 11'(w_quo);
        w_scaled = (w_rem >= 11'(sod_pkg::RAW_MAX)) ? w_quo + 8'd1 : w_quo;
    end

    assign w_last_ch  = (r_ch == sod_pkg::CH_W'(sod_pkg::NUM_STALLS - 1));
    assign w_last_rnd = (r_rnd == sod_pkg::RND_W'(sod_pkg::AVG_ROUNDS - 1));

    always_comb begin
        n_ch  = r_ch;
        n_rnd = r_rnd;
        if (o_push) begin
            if (w_last_ch) begin
                n_ch  = '0;
                n_rnd = w_last_rnd ? '0 : r_rnd + 1'b1;
            end else begin
                n_ch = r_ch + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch  <= '0;
            r_rnd <= '0;
        end else begin
            r_ch  <= n_ch;
            r_rnd <= n_rnd;
        end
    end

    assign o_word.scaled = w_scaled;
    assign o_word.ch     = r_ch;
    assign o_word.done   = w_last_ch && w_last_rnd;

endmodule

// File: rtl/sod_fifo.sv
// Short queue between the front end and the back end.
// Depends on sod_pkg.
module sod_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  sod_pkg::t_work       i_word,
    input  logic                 i_pop,
    output sod_pkg::t_work       o_word,
    output sod_pkg::t_fifo_stat  o_stat
);

    sod_pkg::t_work                    r_mem [sod_pkg::FIFO_DEPTH];
    logic [sod_pkg::FIFO_PTR_W-1:0]    r_wp, r_rp;
    logic [sod_pkg::FIFO_CNT_W-1:0]    r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == sod_pkg::FIFO_PTR_W'(sod_pkg::FIFO_DEPTH - 1)) ?
                        '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == sod_pkg::FIFO_PTR_W'(sod_pkg::FIFO_DEPTH - 1)) ?
                        '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_word;
        end
    end

    assign o_word       = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == sod_pkg::FIFO_CNT_W'(sod_pkg::FIFO_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

endmodule

// File: rtl/sod_back.sv
// Back end: stall sums, window averages, occupancy decisions and result register.
// Also holds the threshold registers. Depends on sod_pkg.
module sod_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  sod_pkg::t_work                   i_word,
    input  sod_pkg::t_fifo_stat              i_stat,
    output logic                             o_pop,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [sod_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sod_pkg::THR_W-1:0]        i_cfg_data,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [sod_pkg::STALL_SLOTS-1:0]  o_mask,
    output logic [sod_pkg::CH_W-1:0]         o_ch,
    output logic                             o_last
);

    localparam int unsigned PROD_W = sod_pkg::SUM_W + sod_pkg::RECIP_W;
    localparam int unsigned QUO_W  = PROD_W - sod_pkg::AVG_SHIFT;
    localparam logic [sod_pkg::STALL_SLOTS-1:0] LANE_MASK =
        sod_pkg::STALL_SLOTS'((2 ** sod_pkg::NUM_STALLS) - 1);

    logic [sod_pkg::SUM_W-1:0]  r_sum  [sod_pkg::STALL_SLOTS];
    logic [sod_pkg::AVG_W-1:0]  r_avg  [sod_pkg::STALL_SLOTS];
    logic [sod_pkg::THR_W-1:0]  r_rise [sod_pkg::STALL_SLOTS];
    logic [sod_pkg::THR_W-1:0]  r_fall [sod_pkg::STALL_SLOTS];
    logic [sod_pkg::STALL_SLOTS-1:0] r_occ, n_occ;

    logic [sod_pkg::SUM_W-1:0]  w_sum_in [sod_pkg::STALL_SLOTS];
    logic [PROD_W-1:0]          w_prod   [sod_pkg::STALL_SLOTS];
    logic [QUO_W-1:0]           w_quo    [sod_pkg::STALL_SLOTS];
    logic [sod_pkg::AVG_W-1:0]  w_new    [sod_pkg::STALL_SLOTS];
    logic [sod_pkg::STALL_SLOTS-1:0] w_fall_hit, w_rise_hit;

    logic r_out_valid;
    logic [sod_pkg::STALL_SLOTS-1:0] r_out_mask;
    logic [sod_pkg::CH_W-1:0]        r_out_ch;
    logic                            r_out_last;

    assign o_pop       = !i_stat.empty && (!r_out_valid || i_ready);
    assign o_cfg_ready = 1'b1;

    // Per-stall lanes: sum with this word, new average by reciprocal, threshold tests.
    always_comb begin
        for (int k = 0; k < sod_pkg::STALL_SLOTS; k++) begin
            w_sum_in[k] = r_sum[k] +
                ((i_word.ch == sod_pkg::CH_W'(k)) ? sod_pkg::SUM_W'(i_word.scaled) : '0);
            w_prod[k]   = PROD_W'(w_sum_in[k]) * PROD_W'(sod_pkg::AVG_RECIP);
            w_quo[k]    = w_prod[k][PROD_W-1:sod_pkg::AVG_SHIFT];
            w_new[k]    = (w_quo[k] > QUO_W'(sod_pkg::SCALED_MAX)) ?
                          sod_pkg::AVG_W'(sod_pkg::SCALED_MAX) : w_quo[k][sod_pkg::AVG_W-1:0];
            w_fall_hit[k] = ({2'b00, r_avg[k]} >
                             ({2'b00, w_new[k]} + {2'b00, r_fall[k]}));
            w_rise_hit[k] = ({2'b00, w_new[k]} >
                             ({2'b00, r_avg[k]} + {2'b00, r_rise[k]}));
            n_occ[k]    = LANE_MASK[k] &&
                          (r_occ[k] ? !w_fall_hit[k] : w_rise_hit[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
            for (int k = 0; k < sod_pkg::STALL_SLOTS; k++) begin
                r_sum[k]  <= '0;
                r_avg[k]  <= '0;
                r_rise[k] <= sod_pkg::THR_W'(sod_pkg::THRESH_RESET);
                r_fall[k] <= sod_pkg::THR_W'(sod_pkg::THRESH_RESET);
            end
        end else begin
            if (o_pop) begin
                if (i_word.done) begin
                    r_occ <= n_occ;
                    for (int k = 0; k < sod_pkg::STALL_SLOTS; k++) begin
                        r_sum[k] <= '0;
                        r_avg[k] <= w_new[k];
                    end
                end else begin
                    r_sum[i_word.ch] <= w_sum_in[i_word.ch];
                end
            end
            if (i_cfg_valid) begin
                if (i_cfg_index < sod_pkg::CFG_IDX_W'(sod_pkg::STALL_SLOTS)) begin
                    r_rise[i_cfg_index[sod_pkg::CH_W-1:0]] <= i_cfg_data;
                end else if (i_cfg_index < sod_pkg::CFG_IDX_W'(2 * sod_pkg::STALL_SLOTS)) begin
                    r_fall[i_cfg_index[sod_pkg::CH_W-1:0]] <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_mask <= (i_word.done ? n_occ : r_occ) & LANE_MASK;
            r_out_ch   <= i_word.ch;
            r_out_last <= i_word.done;
        end
    end

    assign o_valid = r_out_valid;
    assign o_mask  = r_out_mask;
    assign o_ch    = r_out_ch;
    assign o_last  = r_out_last;

endmodule

// File: rtl/stall_occupancy_detector_top.sv
// Top level of the stall occupancy detector: front end, queue and back end.
// Depends on sod_pkg, sod_front, sod_fifo, sod_back and the assertion header.
//
// Usage:
// The input stream carries one raw discharge count per word in s_axis_tdata, credited
// to stalls 0 to 3 in turn. The output stream returns one word per input word:
// the occupancy mask and the stall the sample went to in m_axis_tdata, and
// m_axis_tlast high on the sample that closed an averaging window of four rounds.
// Threshold registers are written through the cfg channel, which is always ready;
// indexes 0 to 3 are rise thresholds, 4 to 7 fall thresholds, others are ignored.
// An accepted word is written into the queue and moves into the result register once that is free.
// Throughput is one word per cycle while neither side stalls; the queue and the output register let input
// and output stall independently. When the receiver stalls, the result register holds
// and the two-entry queue fills, after which s_axis_tready drops.
// Reset is synchronous and active low: stall pointer, round count, sums, averages and
// occupancy clear, thresholds return to 5, the queue and output empty.
`include "stall_occupancy_detector_top_assert.svh"

module stall_occupancy_detector_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // [15:0] raw_count
    input  logic [15:0]                       s_axis_tdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [3:0] occupied_mask, [5:4] sample_channel, [7:6] zero
    output logic [7:0]                        m_axis_tdata,
    output logic                              m_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [sod_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [sod_pkg::THR_W-1:0]         i_cfg_data
);

    sod_pkg::t_work                  w_push_word, w_pop_word;
    sod_pkg::t_fifo_stat             w_stat;
    logic                            w_push, w_pop;
    logic [sod_pkg::STALL_SLOTS-1:0] w_mask;
    logic [sod_pkg::CH_W-1:0]        w_ch;

    sod_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_raw   (s_axis_tdata),
        .i_stat  (w_stat),
        .o_push  (w_push),
        .o_word  (w_push_word)
    );

    sod_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_word  (w_push_word),
        .i_pop   (w_pop),
        .o_word  (w_pop_word),
        .o_stat  (w_stat)
    );

    sod_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_word      (w_pop_word),
        .i_stat      (w_stat),
        .o_pop       (w_pop),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_mask      (w_mask),
        .o_ch        (w_ch),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, w_ch, w_mask};

    `SOD_ASSERT_SAME(a_push_not_full, i_clk, i_rst_n, w_push, !w_stat.full)
    `SOD_ASSERT_SAME(a_pop_not_empty, i_clk, i_rst_n, w_pop, !w_stat.empty)
    `SOD_ASSERT_SAME(a_last_on_final_stall, i_clk, i_rst_n, m_axis_tvalid && m_axis_tlast, m_axis_tdata[5:4] == sod_pkg::CH_W'(sod_pkg::NUM_STALLS - 1))
    `SOD_ASSERT_NEXT(a_pop_fills_output, i_clk, i_rst_n, w_pop, m_axis_tvalid)

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for stall_occupancy_detector_top.
// It drives a directed table and windowed random counts, and checks each output word against
// the table's expected values or an in-bench occupancy predictor. Depends on sod_pkg and the RTL top level.
module tb_top;

    localparam int unsigned REG_RISE_BASE = 0;
    localparam int unsigned REG_FALL_BASE = 4;
    localparam int unsigned REG_LAST      = 7;
    localparam int unsigned CFG_INDEX_TOP = (1 << sod_pkg::CFG_IDX_W) - 1;
    localparam int          CYCLE_LIMIT   = 200000;
    localparam int          DIR_LEN       = 20;
    localparam int          NUM_PHASES    = 6;
    localparam int          RND_PER_PHASE = 140;
    localparam int          HOLD_CYCLES   = 300;

    typedef struct packed {
        logic [3:0]               mask;
        logic                     done;
        logic [sod_pkg::CH_W-1:0] ch;
    } t_occ_status;

    typedef struct packed {
        logic [sod_pkg::RAW_W-1:0] raw;
        logic                      typed;
        logic [3:0]                mask;
        logic                      done;
        logic [sod_pkg::CH_W-1:0]  ch;
    } t_dir_row;

    // One full window: stall 0 and 1 saturate, stall 2 stays dark, stall 3 reads 254.
    localparam t_dir_row DIR_ROWS [DIR_LEN] = '{
        '{16'hFFFF, 1'b1, 4'h0, 1'b0, 2'd0},
        '{16'h0400, 1'b1, 4'h0, 1'b0, 2'd1},
        '{16'h0000, 1'b1, 4'h0, 1'b0, 2'd2},
        '{16'h03FE, 1'b1, 4'h0, 1'b0, 2'd3},
        '{16'h8000, 1'b1, 4'h0, 1'b0, 2'd0},
        '{16'h7FFF, 1'b1, 4'h0, 1'b0, 2'd1},
        '{16'h0000, 1'b1, 4'h0, 1'b0, 2'd2},
        '{16'h03FE, 1'b1, 4'h0, 1'b0, 2'd3},
        '{16'h03FF, 1'b1, 4'h0, 1'b0, 2'd0},
        '{16'h0400, 1'b1, 4'h0, 1'b0, 2'd1},
        '{16'h0000, 1'b1, 4'h0, 1'b0, 2'd2},
        '{16'h03FE, 1'b1, 4'h0, 1'b0, 2'd3},
        '{16'hFFFF, 1'b1, 4'h0, 1'b0, 2'd0},
        '{16'h0400, 1'b1, 4'h0, 1'b0, 2'd1},
        '{16'h0000, 1'b1, 4'h0, 1'b0, 2'd2},
        '{16'h03FE, 1'b1, 4'hB, 1'b1, 2'd3},
        '{16'h0001, 1'b0, 4'h0, 1'b0, 2'd0},
        '{16'h0002, 1'b0, 4'h0, 1'b0, 2'd1},
        '{16'h03FF, 1'b0, 4'h0, 1'b0, 2'd2},
        '{16'h0000, 1'b0, 4'h0, 1'b0, 2'd3}
    };

    logic                            i_clk;
    logic                            i_rst_n;
    logic [sod_pkg::RAW_W-1:0]       s_axis_tdata;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [7:0]                      m_axis_tdata;
    logic                            m_axis_tlast;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [sod_pkg::CFG_IDX_W-1:0]   i_cfg_index;
    logic [sod_pkg::THR_W-1:0]       i_cfg_data;

    logic [sod_pkg::THR_W-1:0] rise_thr [sod_pkg::STALL_SLOTS];
    logic [sod_pkg::THR_W-1:0] fall_thr [sod_pkg::STALL_SLOTS];
    int unsigned      next_stall;
    int unsigned      rounds_done;
    int unsigned      stall_sum [sod_pkg::STALL_SLOTS];
    int unsigned      stall_avg [sod_pkg::STALL_SLOTS];
    logic             stall_occ [sod_pkg::STALL_SLOTS];
    int unsigned      stall_level [sod_pkg::STALL_SLOTS];

    t_occ_status pending_status [$];
    t_occ_status head_status;
    int          mismatches = 0;
    int          cycle_count = 0;
    int          tx_idle_pct = 23;
    int          rx_idle_pct = 61;
    int          rx_hold_left = 0;

    stall_occupancy_detector_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void clear_occupancy_model();
        int k;
        next_stall  = 0;
        rounds_done = 0;
        for (k = 0; k < sod_pkg::STALL_SLOTS; k++) begin
            rise_thr[k]    = sod_pkg::THR_W'(sod_pkg::THRESH_RESET);
            fall_thr[k]    = sod_pkg::THR_W'(sod_pkg::THRESH_RESET);
            stall_sum[k]   = 0;
            stall_avg[k]   = 0;
            stall_occ[k]   = 1'b0;
            stall_level[k] = 0;
        end
    endfunction

    function automatic void note_threshold(input int unsigned idx,
                                           input logic [sod_pkg::THR_W-1:0] val);
        if (idx < REG_FALL_BASE) begin
            rise_thr[idx] = val;
        end else if (idx <= REG_LAST) begin
            fall_thr[idx - REG_FALL_BASE] = val;
        end
    endfunction

    function automatic t_occ_status predict_occupancy(input logic [sod_pkg::RAW_W-1:0] raw);
        t_occ_status res;
        int unsigned ch;
        int unsigned x;
        int unsigned nv;
        int          old_avg;
        int          new_avg;
        int          k;
        ch = next_stall;
        if (ch >= sod_pkg::NUM_STALLS) ch = 0;
        x = (raw > sod_pkg::RAW_MAX) ? sod_pkg::RAW_MAX : int'(raw);
        stall_sum[ch] += (x * sod_pkg::SCALED_MAX) / sod_pkg::RAW_MAX;
        next_stall = ch + 1;
        res.done = 1'b0;
        if (next_stall >= sod_pkg::NUM_STALLS) begin
            next_stall = 0;
            rounds_done++;
        end
        if (rounds_done >= sod_pkg::AVG_ROUNDS) begin
            rounds_done = 0;
            res.done = 1'b1;
            for (k = 0; k < sod_pkg::NUM_STALLS; k++) begin
                old_avg = int'(stall_avg[k]);
                nv = stall_sum[k] / sod_pkg::AVG_ROUNDS;
                if (nv > sod_pkg::SCALED_MAX) nv = sod_pkg::SCALED_MAX;
                stall_avg[k] = nv;
                new_avg = int'(nv);
                stall_sum[k] = 0;
                if (stall_occ[k]) begin
                    if (old_avg - new_avg > int'(fall_thr[k])) stall_occ[k] = 1'b0;
                end else begin
                    if (new_avg - old_avg > int'(rise_thr[k])) stall_occ[k] = 1'b1;
                end
            end
        end
        res.mask = 4'h0;
        for (k = 0; k < sod_pkg::NUM_STALLS; k++) begin
            if (stall_occ[k]) res.mask[k] = 1'b1;
        end
        res.ch = ch[sod_pkg::CH_W-1:0];
        return res;
    endfunction

    function automatic logic [sod_pkg::RAW_W-1:0] pick_count(input int unsigned stall);
        int unsigned r;
        int          v;
        r = $urandom_range(99);
        if (r < 8) return sod_pkg::RAW_W'($urandom_range(16'hFFFF));
        if (r < 12) return sod_pkg::RAW_W'($urandom_range(16'hFFFF, sod_pkg::RAW_MAX + 1));
        v = int'(stall_level[stall]) + int'($urandom_range(16)) - 8;
        if (v < 0) v = 0;
        if (v > int'(sod_pkg::RAW_MAX)) v = sod_pkg::RAW_MAX;
        return sod_pkg::RAW_W'(v);
    endfunction

    task automatic send_count(input logic [sod_pkg::RAW_W-1:0] raw, input logic typed,
                              input t_occ_status typed_status);
        t_occ_status got;
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= raw;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        got = predict_occupancy(raw);
        pending_status.push_back(typed ? typed_status : got);
    endtask

    task automatic write_threshold(input int unsigned idx,
                                   input logic [sod_pkg::THR_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= sod_pkg::CFG_IDX_W'(idx);
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        note_threshold(idx, val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_status.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic program_phase(input int phase);
        int unsigned r;
        int unsigned idx;
        logic [sod_pkg::THR_W-1:0] rise_v;
        logic [sod_pkg::THR_W-1:0] fall_v;
        for (r = 0; r < sod_pkg::NUM_STALLS; r++) begin
            case (phase)
                1: begin
                    rise_v = '0;
                    fall_v = '0;
                end
                2: begin
                    rise_v = '1;
                    fall_v = '1;
                end
                3: begin
                    rise_v = sod_pkg::THR_W'($urandom_range(40));
                    fall_v = sod_pkg::THR_W'($urandom_range(40));
                end
                4: begin
                    rise_v = sod_pkg::THR_W'($urandom_range(15));
                    fall_v = sod_pkg::THR_W'($urandom_range(255));
                end
                default: begin
                    rise_v = sod_pkg::THR_W'($urandom_range(255));
                    fall_v = sod_pkg::THR_W'($urandom_range(255));
                end
            endcase
            write_threshold(REG_RISE_BASE + r, rise_v);
            write_threshold(REG_FALL_BASE + r, fall_v);
        end
        // Writes above the last register must leave every threshold unchanged.
        if (phase == 1 || phase == NUM_PHASES - 1) begin
            for (idx = REG_LAST + 1; idx <= CFG_INDEX_TOP; idx++) begin
                write_threshold(idx, sod_pkg::THR_W'($urandom_range(255)));
            end
        end
    endtask

    task automatic run_random_counts(input int n);
        int i;
        int unsigned k;
        for (i = 0; i < n; i++) begin
            if (next_stall == 0 && rounds_done == 0) begin
                for (k = 0; k < sod_pkg::NUM_STALLS; k++) begin
                    if ($urandom_range(1) == 1) begin
                        stall_level[k] = $urandom_range(sod_pkg::RAW_MAX);
                    end
                end
            end
            send_count(pick_count(next_stall), 1'b0, '0);
        end
    endtask

    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_left > 0) begin
                m_axis_tready <= 1'b0;
                rx_hold_left--;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_status.size() == 0) begin
                $error("unexpected result word: tdata %0h tlast %0b", m_axis_tdata, m_axis_tlast);
                mismatches++;
            end else begin
                head_status = pending_status.pop_front();
                if (m_axis_tdata[3:0] !== head_status.mask) begin
                    $error("occupied_mask: expected %0h, actual %0h",
                           head_status.mask, m_axis_tdata[3:0]);
                    mismatches++;
                end
                if (m_axis_tlast !== head_status.done) begin
                    $error("window_done: expected %0b, actual %0b",
                           head_status.done, m_axis_tlast);
                    mismatches++;
                end
                if (m_axis_tdata[5:4] !== head_status.ch) begin
                    $error("sample_channel: expected %0d, actual %0d",
                           head_status.ch, m_axis_tdata[5:4]);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin
        int phase;
        int i;
        t_occ_status row_status;
        clear_occupancy_model();
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase > 0) begin
                drain_results();
                program_phase(phase);
            end
            if (phase < 2) begin
                tx_idle_pct = 23;
                rx_idle_pct = 61;
            end else if (phase < 4) begin
                tx_idle_pct = 61;
                rx_idle_pct = 23;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (phase == 2) begin
                @(posedge i_clk);
                rx_hold_left = HOLD_CYCLES;
            end
            if (phase == 0) begin
                for (i = 0; i < DIR_LEN; i++) begin
                    row_status.mask = DIR_ROWS[i].mask;
                    row_status.done = DIR_ROWS[i].done;
                    row_status.ch   = DIR_ROWS[i].ch;
                    send_count(DIR_ROWS[i].raw, DIR_ROWS[i].typed, row_status);
                end
            end
            run_random_counts(RND_PER_PHASE);
        end
        drain_results();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && pending_status.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
